FILE: sv/etfp_pkg.sv
// ----------------------------------------------------------------------------
// etfp_pkg
// Shared types, constants and fixed-point helpers for the escape-time block.
// ----------------------------------------------------------------------------
package etfp_pkg;

    // number format: signed, COORD_W bits, FRAC_BITS of them fraction
    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 28;
    localparam int COUNT_W   = 16;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int SUM_W     = (COORD_W + 1 > FRAC_BITS + 3) ? COORD_W + 1 : FRAC_BITS + 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = COORD_W;

    localparam logic signed [COORD_W-1:0] VMAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] VMIN = {1'b1, {(COORD_W-1){1'b0}}};
    // escape threshold, |z|^2 >= 4
    localparam logic [SUM_W-1:0] FOUR = SUM_W'(4) << FRAC_BITS;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_JULIA_MODE   = 2'd0,
        CFG_MAX_ITER     = 2'd1,
        CFG_JULIA_C_REAL = 2'd2,
        CFG_JULIA_C_IMAG = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_re;
        logic signed [COORD_W-1:0] point_im;
    } t_point;

    typedef struct packed {
        logic               bounded;
        logic [COUNT_W-1:0] iterations_done;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
        logic capture;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic finish;
    } t_dp_sts;

    // shift a magnitude product down to the format, restore sign, saturate
    function automatic logic signed [COORD_W-1:0] fx_sat_prod(
        input logic [PROD_W-1:0] prod,
        input logic              neg
    );
        logic [PROD_W-1:0] q;
        q = prod >> FRAC_BITS;
        if (!neg) begin
            if (q > PROD_W'($unsigned(VMAX))) return VMAX;
            return $signed(q[COORD_W-1:0]);
        end
        if (q > PROD_W'($unsigned(VMAX)) + PROD_W'(1)) return VMIN;
        return -$signed(q[COORD_W-1:0]);
    endfunction

    // saturating signed add
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] s;
        s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
        if (s[COORD_W] != s[COORD_W-1]) return s[COORD_W] ? VMIN : VMAX;
        return s[COORD_W-1:0];
    endfunction

endpackage

FILE: sv/etfp_datapath.sv
// ----------------------------------------------------------------------------
// etfp_datapath
// Configuration registers, z/c registers, squaring and cross-product multipliers,
// escape test and result register.
// ----------------------------------------------------------------------------
module etfp_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [etfp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [etfp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  etfp_pkg::t_point                     i_point,
    input  etfp_pkg::t_dp_cmd                    i_cmd,
    output etfp_pkg::t_dp_sts                    o_sts,
    output etfp_pkg::t_result                    o_result
);

    // configuration registers
    logic                                  r_julia_mode;
    logic [etfp_pkg::COUNT_W-1:0]          r_max_iter;
    logic signed [etfp_pkg::COORD_W-1:0]   r_jc_re;
    logic signed [etfp_pkg::COORD_W-1:0]   r_jc_im;

    // iteration state
    logic signed [etfp_pkg::COORD_W-1:0]   r_zr, r_zi, r_cr, r_ci;
    logic [etfp_pkg::COUNT_W-1:0]          r_count;
    logic [etfp_pkg::PROD_W-1:0]           r_p_rr, r_p_ii, r_p_ri;
    logic                                  r_neg_ri;
    etfp_pkg::t_result                     r_result;

    logic [etfp_pkg::COORD_W-1:0]          mag_r, mag_i;
    logic signed [etfp_pkg::COORD_W-1:0]   sx, sy, m, n_zr, n_zi;
    logic [etfp_pkg::SUM_W-1:0]            mag_sum;
    logic                                  in_set;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_julia_mode <= 1'b0;
            r_max_iter   <= etfp_pkg::COUNT_W'(256);
            r_jc_re      <= '0;
            r_jc_im      <= '0;
        end else if (i_cfg_we) begin
            unique case (etfp_pkg::t_cfg_idx'(i_cfg_index))
                etfp_pkg::CFG_JULIA_MODE:   r_julia_mode <= i_cfg_data[0];
                etfp_pkg::CFG_MAX_ITER:     r_max_iter   <= i_cfg_data[etfp_pkg::COUNT_W-1:0];
                etfp_pkg::CFG_JULIA_C_REAL: r_jc_re      <= $signed(i_cfg_data);
                etfp_pkg::CFG_JULIA_C_IMAG: r_jc_im      <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // magnitudes feeding the multipliers
    assign mag_r = r_zr[etfp_pkg::COORD_W-1] ? $unsigned(-r_zr) : $unsigned(r_zr);
    assign mag_i = r_zi[etfp_pkg::COORD_W-1] ? $unsigned(-r_zi) : $unsigned(r_zi);

    // scaled squares and cross product from the registered products
    assign sx = etfp_pkg::fx_sat_prod(r_p_rr, 1'b0);
    assign sy = etfp_pkg::fx_sat_prod(r_p_ii, 1'b0);
    assign m  = etfp_pkg::fx_sat_prod(r_p_ri, r_neg_ri);

    // escape test on the exact sum of the squares
    assign mag_sum = etfp_pkg::SUM_W'($unsigned(sx)) + etfp_pkg::SUM_W'($unsigned(sy));
    assign in_set  = mag_sum < etfp_pkg::FOUR;

    assign o_sts.finish = !in_set || (r_count >= r_max_iter);

    // next z, both squares are non-negative so their difference cannot overflow
    assign n_zr = etfp_pkg::sat_add(sx - sy, r_cr);
    assign n_zi = etfp_pkg::sat_add(etfp_pkg::sat_add(m, m), r_ci);

    // iteration registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (r_julia_mode) begin
                r_zr <= i_point.point_re;
                r_zi <= i_point.point_im;
                r_cr <= r_jc_re;
                r_ci <= r_jc_im;
            end else begin
                r_zr <= '0;
                r_zi <= '0;
                r_cr <= i_point.point_re;
                r_ci <= i_point.point_im;
            end
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_zr    <= n_zr;
            r_zi    <= n_zi;
            r_count <= r_count + etfp_pkg::COUNT_W'(1);
        end
        if (i_cmd.mul) begin
            r_p_rr   <= etfp_pkg::PROD_W'(mag_r) * etfp_pkg::PROD_W'(mag_r);
            r_p_ii   <= etfp_pkg::PROD_W'(mag_i) * etfp_pkg::PROD_W'(mag_i);
            r_p_ri   <= etfp_pkg::PROD_W'(mag_r) * etfp_pkg::PROD_W'(mag_i);
            r_neg_ri <= r_zr[etfp_pkg::COORD_W-1] ^ r_zi[etfp_pkg::COORD_W-1];
        end
        if (i_cmd.capture) begin
            r_result.bounded         <= in_set;
            r_result.iterations_done <= r_count;
        end
    end

    assign o_result = r_result;

endmodule

FILE: sv/etfp_ctrl.sv
// ----------------------------------------------------------------------------
// etfp_ctrl
// Sequencer for the load / multiply / evaluate loop and output word valid.
// ----------------------------------------------------------------------------
module etfp_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  etfp_pkg::t_dp_sts  i_sts,
    output etfp_pkg::t_dp_cmd  o_cmd
);

    etfp_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= etfp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            etfp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = etfp_pkg::ST_MUL;
                end
            end
            etfp_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = etfp_pkg::ST_EVAL;
            end
            etfp_pkg::ST_EVAL: begin
                if (i_sts.finish) begin
                    // wait here while the previous word is still unread
                    if (!r_out_valid || i_out_ready) begin
                        o_cmd.capture = 1'b1;
                        n_out_valid   = 1'b1;
                        n_state       = etfp_pkg::ST_IDLE;
                    end
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = etfp_pkg::ST_MUL;
                end
            end
            default: n_state = etfp_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/escape_time_fractal_point.sv
// Each iteration runs as two states: ST_MUL on the three multipliers, then ST_EVAL
// for scaling, escape test and update. A new point is taken only after the result
// of the last one has been captured, so the block works on one point at a time.
// Output word is held in a register, so a new point is taken while it waits.
// Reset (i_rst_n low, synchronous) idles the sequencer, drops output valid and
// loads the configuration registers with Mandelbrot mode, limit 256 and Julia c of zero.
// ----------------------------------------------------------------------------
// escape_time_fractal_point
// Escape-time iteration of z = z^2 + c for Mandelbrot and Julia points.
// ----------------------------------------------------------------------------
module escape_time_fractal_point (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [etfp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [etfp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  etfp_pkg::t_point                   i_in_point,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output etfp_pkg::t_result                  o_out_result
);

    etfp_pkg::t_dp_cmd cmd;
    etfp_pkg::t_dp_sts sts;

    // sequencer
    etfp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and registers
    etfp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_point     (i_in_point),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_result    (o_out_result)
    );

endmodule

FILE: sv/etfp_checker.sv
// ----------------------------------------------------------------------------
// etfp_checker
// Port-level checks on the escape-time block, bound to the top level.
// ----------------------------------------------------------------------------
module etfp_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  etfp_pkg::t_result                  o_out_result
);

    // reset drops output valid
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_result))
        else $error("output word changed while stalled");

    // one point at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while busy");

    // a result passes through the multiply and evaluate states before output valid rises
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result too early after accept");

endmodule

bind escape_time_fractal_point etfp_checker u_etfp_checker (.*);
